// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when compiled for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TDF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TDF_ASSERT_NEVER(name, cond, msg) \
  `TDF_ASSERT(name, !(cond), msg)
`else
`define TDF_ASSERT(name, prop, msg)
`define TDF_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// File: hw/rtl/tdf_pkg.sv
// Types, constants and helpers for the trial division factorizer.
package tdf_pkg;

  localparam int unsigned PRIME_W     = 32;
  localparam int unsigned EXP_W       = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned RES_CNT_W   = 4;

  localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;

  localparam logic [STATUS_W-1:0] STATUS_FACTOR = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ONE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO   = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_DIV   = 6'b000100,
    S_EVAL  = 6'b001000,
    S_LEFT  = 6'b010000,
    S_FINAL = 6'b100000
  } state_e;

  function automatic logic [EXP_W-1:0] exp_inc(input logic [EXP_W-1:0] e);
    exp_inc = (e == EXP_MAX) ? e : e + EXP_W'(1);
  endfunction

endpackage

// File: hw/rtl/trial_division_factorizer.sv
// Trial division prime factorizer: top level with shared restoring divider.
//
// Usage: drive number_i and pulse start while busy is low; the request is
// taken at that clock edge. The block then emits the prime factorization as
// a run of results, ascending by prime, each on prime_o/exponent_o/last_o/
// status_o for exactly one cycle with result_valid_o high; last_o marks the
// final one. Inputs of zero and one give a single marker result (status 2 or
// 1) in the cycle after the request, and busy stays low.
// Sequence: the shift stage strips the factors of two one at a time, then
// one trial division runs per odd divisor and per successful division, each
// on the single bit-serial divider (WIDTH steps plus an evaluate state),
// and the LEFT and FINAL states close out. A 32-bit prime takes about
// 32768 trials; highly composite inputs finish far sooner. One request is
// processed at a time.
// Results cannot be held off: each is valid for one cycle only.
// Reset returns the sequencer to idle and drops any request in progress.
module trial_division_factorizer #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [WIDTH-1:0]                  number_i,
  output logic                              result_valid_o,
  output logic [tdf_pkg::PRIME_W-1:0]       prime_o,
  output logic [tdf_pkg::EXP_W-1:0]         exponent_o,
  output logic                              last_o,
  output logic [tdf_pkg::STATUS_W-1:0]      status_o
);

  localparam int unsigned CW = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

  tdf_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] d_q, d_d;
  logic [tdf_pkg::EXP_W-1:0] e_q, e_d;
  logic inner_q, inner_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic pend_vld_q, pend_vld_d;
  logic [WIDTH-1:0] pend_prime_q, pend_prime_d;
  logic [tdf_pkg::EXP_W-1:0] pend_exp_q, pend_exp_d;
  logic [tdf_pkg::RES_CNT_W-1:0] res_cnt_q, res_cnt_d;

  logic valid_q, valid_d;
  logic [tdf_pkg::PRIME_W-1:0] prime_q, prime_d;
  logic [tdf_pkg::EXP_W-1:0] exp_q, exp_d;
  logic last_q, last_d;
  logic [tdf_pkg::STATUS_W-1:0] status_q, status_d;

  logic [WIDTH:0] trial_rem;
  logic [WIDTH:0] trial_diff;
  logic fits;

  logic start_div;
  logic [WIDTH-1:0] div_src;
  logic nf_valid;
  logic [WIDTH-1:0] nf_prime;
  logic [tdf_pkg::EXP_W-1:0] nf_exp;

  // one restoring step per cycle
  assign trial_rem  = {rem_q, quo_q[WIDTH-1]};
  assign trial_diff = trial_rem - {1'b0, d_q};
  assign fits       = ~trial_diff[WIDTH];

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    d_d          = d_q;
    e_d          = e_q;
    inner_d      = inner_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    pend_vld_d   = pend_vld_q;
    pend_prime_d = pend_prime_q;
    pend_exp_d   = pend_exp_q;
    res_cnt_d    = res_cnt_q;
    valid_d      = 1'b0;
    prime_d      = prime_q;
    exp_d        = exp_q;
    last_d       = last_q;
    status_d     = status_q;
    start_div    = 1'b0;
    div_src      = n_q;
    nf_valid     = 1'b0;
    nf_prime     = d_q;
    nf_exp       = e_q;

    case (state_q)
      tdf_pkg::S_IDLE: begin
        if (start) begin
          if (number_i == '0) begin
            valid_d  = 1'b1;
            prime_d  = '0;
            exp_d    = '0;
            last_d   = 1'b1;
            status_d = tdf_pkg::STATUS_ZERO;
          end else if (number_i == WIDTH'(1)) begin
            valid_d  = 1'b1;
            prime_d  = '0;
            exp_d    = '0;
            last_d   = 1'b1;
            status_d = tdf_pkg::STATUS_ONE;
          end else begin
            n_d        = number_i;
            e_d        = '0;
            pend_vld_d = 1'b0;
            res_cnt_d  = '0;
            state_d    = tdf_pkg::S_SHIFT;
          end
        end
      end
      tdf_pkg::S_SHIFT: begin
        if (!n_q[0]) begin
          n_d = n_q >> 1;
          e_d = tdf_pkg::exp_inc(e_q);
        end else begin
          if (e_q != '0) begin
            pend_vld_d   = 1'b1;
            pend_prime_d = WIDTH'(2);
            pend_exp_d   = e_q;
          end
          e_d       = '0;
          d_d       = WIDTH'(3);
          inner_d   = 1'b0;
          start_div = 1'b1;
          div_src   = n_q;
          state_d   = tdf_pkg::S_DIV;
        end
      end
      tdf_pkg::S_DIV: begin
        quo_d = {quo_q[WIDTH-2:0], fits};
        rem_d = fits ? trial_diff[WIDTH-1:0] : trial_rem[WIDTH-1:0];
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = tdf_pkg::S_EVAL;
        end
      end
      tdf_pkg::S_EVAL: begin
        if (!inner_q && (d_q > quo_q)) begin
          state_d = tdf_pkg::S_LEFT;
        end else if (rem_q == '0) begin
          n_d       = quo_q;
          e_d       = tdf_pkg::exp_inc(e_q);
          inner_d   = 1'b1;
          start_div = 1'b1;
          div_src   = quo_q;
          state_d   = tdf_pkg::S_DIV;
        end else begin
          nf_valid  = (e_q != '0);
          nf_prime  = d_q;
          nf_exp    = e_q;
          e_d       = '0;
          inner_d   = 1'b0;
          d_d       = d_q + WIDTH'(2);
          start_div = 1'b1;
          div_src   = n_q;
          state_d   = tdf_pkg::S_DIV;
        end
      end
      tdf_pkg::S_LEFT: begin
        // leftover remainder above one is a prime
        nf_valid = (n_q > WIDTH'(1));
        nf_prime = n_q;
        nf_exp   = tdf_pkg::EXP_W'(1);
        state_d  = tdf_pkg::S_FINAL;
      end
      tdf_pkg::S_FINAL: begin
        valid_d  = 1'b1;
        prime_d  = tdf_pkg::PRIME_W'(pend_prime_q);
        exp_d    = pend_exp_q;
        last_d   = 1'b1;
        status_d = tdf_pkg::STATUS_FACTOR;
        state_d  = tdf_pkg::S_IDLE;
      end
      default: begin
        state_d = tdf_pkg::S_IDLE;
      end
    endcase

    if (start_div) begin
      quo_d = div_src;
      rem_d = '0;
      cnt_d = CNT_LAST;
    end

    // hold one factor back so the final one can carry last
    if (nf_valid) begin
      if (!pend_vld_q) begin
        pend_vld_d   = 1'b1;
        pend_prime_d = nf_prime;
        pend_exp_d   = nf_exp;
      end else if (res_cnt_q < tdf_pkg::RES_CNT_W'(tdf_pkg::MAX_RESULTS - 1)) begin
        valid_d      = 1'b1;
        prime_d      = tdf_pkg::PRIME_W'(pend_prime_q);
        exp_d        = pend_exp_q;
        last_d       = 1'b0;
        status_d     = tdf_pkg::STATUS_FACTOR;
        res_cnt_d    = res_cnt_q + tdf_pkg::RES_CNT_W'(1);
        pend_prime_d = nf_prime;
        pend_exp_d   = nf_exp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tdf_pkg::S_IDLE;
      valid_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      res_cnt_q  <= '0;
      inner_q    <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      pend_vld_q <= pend_vld_d;
      res_cnt_q  <= res_cnt_d;
      inner_q    <= inner_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    d_q          <= d_d;
    e_q          <= e_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    pend_prime_q <= pend_prime_d;
    pend_exp_q   <= pend_exp_d;
    prime_q      <= prime_d;
    exp_q        <= exp_d;
    last_q       <= last_d;
    status_q     <= status_d;
  end

  assign busy           = (state_q != tdf_pkg::S_IDLE);
  assign result_valid_o = valid_q;
  assign prime_o        = prime_q;
  assign exponent_o     = exp_q;
  assign last_o         = last_q;
  assign status_o       = status_q;

`include "assert_macros.svh"

  `TDF_ASSERT(a_idle_result_last, (result_valid_o && !busy) |-> last_o, "idle result not last")
  `TDF_ASSERT(a_marker_shape, (result_valid_o && status_o != tdf_pkg::STATUS_FACTOR) |-> (last_o && prime_o == '0 && exponent_o == '0), "bad marker result")
  `TDF_ASSERT_NEVER(a_factor_exp_zero, result_valid_o && status_o == tdf_pkg::STATUS_FACTOR && exponent_o == '0, "factor with zero exponent")
  `TDF_ASSERT(a_final_has_pending, (state_q == tdf_pkg::S_FINAL) |-> pend_vld_q, "final without pending factor")
  `TDF_ASSERT(a_divisor_odd, (state_q == tdf_pkg::S_DIV) |-> d_q[0], "even trial divisor")

endmodule
